>>> rtl/core/gsrs_pkg.sv
// shared constants and types for the genomic site run segmenter
// no dependencies; imported by every module of the block
package gsrs_pkg;

    // default sizes handed to the top-level parameters
    localparam int POS_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int CHROM_W = 8;
    localparam int READS_W = 16;
    localparam int SSCORE_W = 16;
    localparam int DSCORE_W = 32;
    localparam int DGAP_W  = 32;

    localparam logic [DGAP_W-1:0] DESERT_GAP_RST = 32'd2000;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // which of the two result slots the core produced this cycle
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

>>> rtl/core/genomic_site_run_segmenter_top.sv
// top level of the genomic site run segmenter
// depends on gsrs_pkg, gsrs_core and gsrs_queue
//
//  channel | direction | handshake          | carries
//  --------+-----------+--------------------+------------------------------------
//  s_      | in        | s_valid / s_ready  | one site request per transfer
//  m_      | out       | m_valid / m_ready  | one foreground domain per transfer
//  cfg_    | in        | cfg_we only        | desert_gap, written with no wait
//
// a site request is registered, processed once the queue has room, and its domains
// land in a four-entry result queue; one request per cycle sustained while the
// queue has room
// a request that closes a run and flushes another yields two domains, which drain
// one per cycle while m_ready is high; the queue needs room for two before a
// request is processed; m_ready low fills the queue and then holds s_ready low;
// synchronous active-low reset clears the run state and sets desert_gap to 2000
module genomic_site_run_segmenter_top import gsrs_pkg::*; #(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [DGAP_W-1:0]     cfg_wdata,
    // site requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHROM_W-1:0]    s_site_chrom,
    input  logic [POS_BITS-1:0]   s_site_start,
    input  logic [POS_BITS-1:0]   s_site_end,
    input  logic [READS_W-1:0]    s_read_count,
    input  logic                  s_site_class,
    input  logic [SSCORE_W-1:0]   s_site_score,
    input  logic                  s_stream_last,
    // domains
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHROM_W-1:0]    m_dom_chrom,
    output logic [POS_BITS-1:0]   m_dom_start,
    output logic [POS_BITS-1:0]   m_dom_end,
    output logic [COUNT_BITS-1:0] m_dom_sites,
    output logic [DSCORE_W-1:0]   m_dom_score,
    output logic                  m_result_last
);

    localparam int RES_W = CHROM_W + 2 * POS_BITS + COUNT_BITS + DSCORE_W + 1;

    // desert gap register
    logic [DGAP_W-1:0] desert_gap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desert_gap_reg <= DESERT_GAP_RST;
        end else if (cfg_we) begin
            desert_gap_reg <= cfg_wdata;
        end
    end

    // input register: one site request waiting for the core
    logic                  in_valid_reg, in_valid_next;
    logic [CHROM_W-1:0]    chrom_reg;
    logic [POS_BITS-1:0]   start_reg;
    logic [POS_BITS-1:0]   end_reg;
    logic [READS_W-1:0]    reads_reg;
    logic                  class_reg;
    logic [SSCORE_W-1:0]   score_reg;
    logic                  last_reg;

    logic                  room;
    logic                  take;
    logic                  s_fire;

    // core consumes the held request only when the queue can absorb two domains
    assign take          = in_valid_reg && room;
    assign s_ready       = !in_valid_reg || take;
    assign s_fire        = s_valid && s_ready;
    assign in_valid_next = s_fire || (in_valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            chrom_reg <= s_site_chrom;
            start_reg <= s_site_start;
            end_reg   <= s_site_end;
            reads_reg <= s_read_count;
            class_reg <= s_site_class;
            score_reg <= s_site_score;
            last_reg  <= s_stream_last;
        end
    end

    // segmentation core
    push_t            push;
    logic [RES_W-1:0] res0;
    logic [RES_W-1:0] res1;
    logic [RES_W-1:0] qout;

    gsrs_core #(
        .POS_BITS   (POS_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .desert_gap  (desert_gap_reg),
        .site_chrom  (chrom_reg),
        .site_start  (start_reg),
        .site_end    (end_reg),
        .read_count  (reads_reg),
        .site_class  (class_reg),
        .site_score  (score_reg),
        .stream_last (last_reg),
        .push        (push),
        .res0        (res0),
        .res1        (res1)
    );

    // result queue
    gsrs_queue #(
        .WIDTH (RES_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .din0      (res0),
        .din1      (res1),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .dout      (qout)
    );

    // unpack {last, score, sites, end, start, chrom}
    assign {m_result_last, m_dom_score, m_dom_sites, m_dom_end,
            m_dom_start, m_dom_chrom} = qout;

endmodule

>>> rtl/core/gsrs_core.sv
// segmentation state and per-site next-state logic
// depends on gsrs_pkg; produces up to two packed domain records per site
module gsrs_core import gsrs_pkg::*; #(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int RES_W     = CHROM_W + 2 * POS_BITS + COUNT_BITS + DSCORE_W + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  logic [DGAP_W-1:0]     desert_gap,
    input  logic [CHROM_W-1:0]    site_chrom,
    input  logic [POS_BITS-1:0]   site_start,
    input  logic [POS_BITS-1:0]   site_end,
    input  logic [READS_W-1:0]    read_count,
    input  logic                  site_class,
    input  logic [SSCORE_W-1:0]   site_score,
    input  logic                  stream_last,
    output push_t                 push,
    output logic [RES_W-1:0]      res0,
    output logic [RES_W-1:0]      res1
);

    localparam int CMP_W = (POS_BITS > DGAP_W) ? POS_BITS : DGAP_W;

    logic                  have_open_reg, have_open_next;
    logic [CHROM_W-1:0]    prev_chrom_reg, prev_chrom_next;
    logic [POS_BITS-1:0]   prev_end_reg, prev_end_next;
    logic                  prev_class_reg, prev_class_next;
    logic [CHROM_W-1:0]    run_chrom_reg, run_chrom_next;
    logic [POS_BITS-1:0]   run_start_reg, run_start_next;
    logic [COUNT_BITS-1:0] run_sites_reg, run_sites_next;
    logic [DSCORE_W-1:0]   run_score_reg, run_score_next;

    logic                  kept;
    logic [POS_BITS-1:0]   gap;
    logic                  brk;
    logic [DSCORE_W:0]     score_sum;
    logic                  emit0, emit1;

    assign kept      = (read_count != '0);
    // overlapping sites count as adjacent
    assign gap       = (site_start >= prev_end_reg) ? (site_start - prev_end_reg) : '0;
    assign brk       = (site_chrom != prev_chrom_reg) ||
                       (CMP_W'(gap) > CMP_W'(desert_gap));
    assign score_sum = {1'b0, run_score_reg} + (DSCORE_W + 1)'(site_score);

    always_comb begin
        have_open_next  = have_open_reg;
        prev_chrom_next = prev_chrom_reg;
        prev_end_next   = prev_end_reg;
        prev_class_next = prev_class_reg;
        run_chrom_next  = run_chrom_reg;
        run_start_next  = run_start_reg;
        run_sites_next  = run_sites_reg;
        run_score_next  = run_score_reg;
        emit0           = 1'b0;
        emit1           = 1'b0;
        if (take) begin
            if (kept) begin
                if (have_open_reg && !brk && (site_class == prev_class_reg)) begin
                    // same run continues
                    if (run_sites_reg != '1) begin
                        run_sites_next = run_sites_reg + 1'b1;
                    end
                    run_score_next = score_sum[DSCORE_W] ? '1 : score_sum[DSCORE_W-1:0];
                end else begin
                    // close the old run if it was foreground, open a new one
                    emit0          = have_open_reg && prev_class_reg;
                    run_chrom_next = site_chrom;
                    run_start_next = site_start;
                    run_sites_next = COUNT_BITS'(1);
                    run_score_next = DSCORE_W'(site_score);
                    have_open_next = 1'b1;
                end
                prev_chrom_next = site_chrom;
                prev_end_next   = site_end;
                prev_class_next = site_class;
            end
            if (stream_last && have_open_next) begin
                emit1          = prev_class_next;
                have_open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_open_reg  <= 1'b0;
            prev_chrom_reg <= '0;
            prev_end_reg   <= '0;
            prev_class_reg <= 1'b0;
            run_chrom_reg  <= '0;
            run_start_reg  <= '0;
            run_sites_reg  <= '0;
            run_score_reg  <= '0;
        end else begin
            have_open_reg  <= have_open_next;
            prev_chrom_reg <= prev_chrom_next;
            prev_end_reg   <= prev_end_next;
            prev_class_reg <= prev_class_next;
            run_chrom_reg  <= run_chrom_next;
            run_start_reg  <= run_start_next;
            run_sites_reg  <= run_sites_next;
            run_score_reg  <= run_score_next;
        end
    end

    // record layout: {last, score, sites, end, start, chrom}
    assign res0 = {!emit1, run_score_reg, run_sites_reg, prev_end_reg,
                   run_start_reg, run_chrom_reg};
    assign res1 = {1'b1, run_score_next, run_sites_next, prev_end_next,
                   run_start_next, run_chrom_next};

    assign push.first  = emit0;
    assign push.second = emit1;

endmodule

>>> rtl/core/gsrs_queue.sv
// small result queue: takes up to two records a cycle, hands out one
// depends on gsrs_pkg for depth and push_t
module gsrs_queue import gsrs_pkg::*; #(
    parameter int WIDTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  push_t            push,
    input  logic [WIDTH-1:0] din0,
    input  logic [WIDTH-1:0] din1,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QPTR_W-1:0] waddr1;
    logic              pop;

    assign pop       = out_valid && out_ready;
    assign waddr1    = wptr_reg + QPTR_W'(push.first);
    assign wptr_next = wptr_reg + QPTR_W'(push.first) + QPTR_W'(push.second);
    assign rptr_next = rptr_reg + QPTR_W'(pop);
    assign cnt_next  = cnt_reg + QCNT_W'(push.first) + QCNT_W'(push.second) - QCNT_W'(pop);

    // room for a full pair of records
    assign room      = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign dout      = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.first) begin
            mem_reg[wptr_reg] <= din0;
        end
        if (push.second) begin
            mem_reg[waddr1] <= din1;
        end
    end

endmodule

>>> sim/genomic_site_run_segmenter_top_tb.sv
// self-checking testbench for genomic_site_run_segmenter_top
// needs gsrs_pkg and the segmenter rtl; a built-in domain predictor checks every result
module genomic_site_run_segmenter_top_tb;
    import gsrs_pkg::*;

    localparam int POS_W          = POS_BITS_DEF;
    localparam int CNT_W          = COUNT_BITS_DEF;
    // cycles with no accepted site request and no expected domain taken before the run is
    // abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last expected domain
    localparam int SETTLE_CYCLES  = 6;
    // sites in the long foreground run
    localparam int LONG_RUN_SITES = 30;

    // one site request as the sender sees it
    typedef struct packed {
        logic [CHROM_W-1:0]  chrom;
        logic [POS_W-1:0]    start;
        logic [POS_W-1:0]    stop;
        logic [READS_W-1:0]  reads;
        logic                cls;
        logic [SSCORE_W-1:0] score;
        logic                last;
    } site_t;

    // one foreground domain as the block reports it
    typedef struct packed {
        logic [CHROM_W-1:0]  chrom;
        logic [POS_W-1:0]    start;
        logic [POS_W-1:0]    stop;
        logic [CNT_W-1:0]    sites;
        logic [DSCORE_W-1:0] score;
        logic                last;
    } domain_t;

    // clock, reset and block ports; the driven ones are known from time zero
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [DGAP_W-1:0]     cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [CHROM_W-1:0]    s_site_chrom  = '0;
    logic [POS_W-1:0]      s_site_start  = '0;
    logic [POS_W-1:0]      s_site_end    = '0;
    logic [READS_W-1:0]    s_read_count  = '0;
    logic                  s_site_class  = 1'b0;
    logic [SSCORE_W-1:0]   s_site_score  = '0;
    logic                  s_stream_last = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [CHROM_W-1:0]    m_dom_chrom;
    logic [POS_W-1:0]      m_dom_start;
    logic [POS_W-1:0]      m_dom_end;
    logic [CNT_W-1:0]      m_dom_sites;
    logic [DSCORE_W-1:0]   m_dom_score;
    logic                  m_result_last;

    // predictor copy of the segmenter state and its register
    logic [DGAP_W-1:0]     gap_limit = DESERT_GAP_RST;
    logic                  run_open  = 1'b0;
    logic [CHROM_W-1:0]    last_chrom = '0;
    logic [POS_W-1:0]      last_end   = '0;
    logic                  last_cls   = 1'b0;
    logic [CHROM_W-1:0]    run_chrom  = '0;
    logic [POS_W-1:0]      run_start  = '0;
    logic [CNT_W-1:0]      run_sites  = '0;
    logic [DSCORE_W-1:0]   run_score  = '0;

    // domains predicted but not yet seen on the result channel
    domain_t               domains_due[$];
    domain_t               want;
    domain_t               got;
    int                    errors       = 0;
    int                    quiet_cycles = 0;
    // when set, neither side inserts idle cycles
    bit                    no_idle      = 1'b0;

    // random stream cursor: keeps most generated sites sorted along one chromosome
    logic [CHROM_W-1:0]    gen_chrom = 8'd1;
    logic [POS_W-1:0]      gen_pos   = '0;
    logic                  gen_cls   = 1'b0;

    genomic_site_run_segmenter_top #(
        .POS_BITS   (POS_W),
        .COUNT_BITS (CNT_W)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_site_chrom  (s_site_chrom),
        .s_site_start  (s_site_start),
        .s_site_end    (s_site_end),
        .s_read_count  (s_read_count),
        .s_site_class  (s_site_class),
        .s_site_score  (s_site_score),
        .s_stream_last (s_stream_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dom_chrom   (m_dom_chrom),
        .m_dom_start   (m_dom_start),
        .m_dom_end     (m_dom_end),
        .m_dom_sites   (m_dom_sites),
        .m_dom_score   (m_dom_score),
        .m_result_last (m_result_last)
    );

    // 10 unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // domain built from the open run; the end is the last kept site's end
    function automatic domain_t close_run();
        domain_t d;
        d.chrom = run_chrom;
        d.start = run_start;
        d.stop  = last_end;
        d.sites = run_sites;
        d.score = run_score;
        d.last  = 1'b0;
        return d;
    endfunction

    // advance the predicted state by one accepted site request, queue its domains
    task automatic predict_site(input site_t st);
        domain_t             outs[2];
        int                  n;
        logic [POS_W-1:0]    gap;
        logic                brk;
        logic [DSCORE_W:0]   sum;
        n = 0;
        if (st.reads != '0) begin
            if (run_open) begin
                // overlapping or unsorted sites count as adjacent
                gap = (st.start >= last_end) ? st.start - last_end : '0;
                brk = (st.chrom != last_chrom) || (gap > gap_limit);
                if (brk || st.cls != last_cls) begin
                    // background runs end without a domain
                    if (last_cls) begin
                        outs[n] = close_run();
                        n++;
                    end
                    run_chrom = st.chrom;
                    run_start = st.start;
                    run_sites = CNT_W'(1);
                    run_score = DSCORE_W'(st.score);
                end else begin
                    if (run_sites != '1) run_sites++;
                    sum       = {1'b0, run_score} + (DSCORE_W + 1)'(st.score);
                    run_score = sum[DSCORE_W] ? '1 : sum[DSCORE_W-1:0];
                end
            end else begin
                // fresh run after reset or flush, no gap or chromosome test
                run_chrom = st.chrom;
                run_start = st.start;
                run_sites = CNT_W'(1);
                run_score = DSCORE_W'(st.score);
                run_open  = 1'b1;
            end
            last_chrom = st.chrom;
            last_end   = st.stop;
            last_cls   = st.cls;
        end
        // stream end flushes the open run, even on a dropped site
        if (st.last && run_open) begin
            if (last_cls) begin
                outs[n] = close_run();
                n++;
            end
            run_open = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            outs[i].last = (i == n - 1);
            domains_due.insert(domains_due.size(), outs[i]);
        end
    endtask

    // ---------------------------------------------------------------- drivers

    function automatic site_t mk_site(input logic [CHROM_W-1:0] chrom,
                                      input logic [POS_W-1:0] start,
                                      input logic [POS_W-1:0] stop,
                                      input logic [READS_W-1:0] reads,
                                      input logic cls,
                                      input logic [SSCORE_W-1:0] score,
                                      input logic last);
        site_t st;
        st.chrom = chrom;
        st.start = start;
        st.stop  = stop;
        st.reads = reads;
        st.cls   = cls;
        st.score = score;
        st.last  = last;
        return st;
    endfunction

    // present one site request after a random pause and hold it until accepted
    task automatic send_site(input site_t st);
        int pause;
        @(negedge aclk);
        pause = no_idle ? 0 : $urandom_range(0, 6);
        // valid only drops when a pause is wanted, never lowered and raised in one step
        if (pause != 0) begin
            s_valid = 1'b0;
            repeat (pause) @(negedge aclk);
        end
        s_site_chrom  = st.chrom;
        s_site_start  = st.start;
        s_site_end    = st.stop;
        s_read_count  = st.reads;
        s_site_class  = st.cls;
        s_site_score  = st.score;
        s_stream_last = st.last;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_site(st);
    endtask

    // drop valid, wait for every predicted domain, then let the pipeline empty
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (domains_due.size() != 0) @(posedge aclk);
        // dropped and background sites leave no result to wait for
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write desert_gap only while nothing is in flight
    task automatic set_gap(input logic [DGAP_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        gap_limit = value;
    endtask

    // result side: random stall per domain, then ready until one is taken
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ---------------------------------------------------------------- checker

    // every accepted domain is matched against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.chrom = m_dom_chrom;
            got.start = m_dom_start;
            got.stop  = m_dom_end;
            got.sites = m_dom_sites;
            got.score = m_dom_score;
            got.last  = m_result_last;
            if (domains_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected domain: chrom %0d start %h end %h sites %0d score %h",
                             got.chrom, got.start, got.stop, got.sites, got.score);
            end else begin
                want = domains_due.pop_front();
                if (got.chrom !== want.chrom || got.start !== want.start ||
                    got.stop !== want.stop || got.sites !== want.sites ||
                    got.score !== want.score || got.last !== want.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("domain mismatch (exp/got): chrom %0d/%0d start %h/%h end %h/%h",
                                 want.chrom, got.chrom, want.start, got.start,
                                 want.stop, got.stop);
                        $display("  sites %0d/%0d score %h/%h last %0b/%0b",
                                 want.sites, got.sites, want.score, got.score,
                                 want.last, got.last);
                    end
                end
            end
        end
    end

    // count cycles in which no site request is taken and no expected domain comes out
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) ||
            (m_valid && m_ready && domains_due.size() != 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // class changes, desert gaps at and past the limit, chromosome change, overlap
    task automatic test_runs_and_breaks();
        send_site(mk_site(8'd1, 100, 200, 5, 1'b1, 16'hFFFF, 1'b0));
        send_site(mk_site(8'd1, 300, 400, 1, 1'b1, 16'hFFFF, 1'b0));
        // class change closes the foreground run
        send_site(mk_site(8'd1, 450, 500, 7, 1'b0, 16'h1234, 1'b0));
        send_site(mk_site(8'd1, 600, 700, 3, 1'b0, 16'h0010, 1'b0));
        // gap one past the limit ends the background run silently
        send_site(mk_site(8'd1, 2701, 2800, 2, 1'b1, 16'h8000, 1'b0));
        // zero reads: dropped, no state change
        send_site(mk_site(8'd1, 2900, 3000, 0, 1'b1, 16'hFFFF, 1'b0));
        // chromosome change
        send_site(mk_site(8'd2, 50, 80, 9, 1'b1, 16'h0001, 1'b0));
        // overlapping site counts as adjacent
        send_site(mk_site(8'd2, 60, 120, 4, 1'b1, 16'h0002, 1'b0));
        // gap exactly at the limit stays in the segment
        send_site(mk_site(8'd2, 2120, 2200, 4, 1'b1, 16'h0003, 1'b0));
        // break plus flush on one request: two domains
        send_site(mk_site(8'd2, 4201, 4300, 4, 1'b1, 16'h0004, 1'b1));
    endtask

    // stream end on dropped and kept sites, with and without an open run
    task automatic test_flush_cases();
        send_site(mk_site(8'd7, 10, 20, 1, 1'b0, 16'h0005, 1'b0));
        // dropped final site still flushes, background so nothing comes out
        send_site(mk_site(8'd7, 30, 40, 0, 1'b1, 16'h0005, 1'b1));
        // dropped final site with nothing open
        send_site(mk_site(8'd9, 0, 5, 0, 1'b0, 16'h0000, 1'b1));
        // single-site foreground run opened and flushed together
        send_site(mk_site(8'd4, 1000, 1100, 1, 1'b1, 16'hABCD, 1'b1));
        send_site(mk_site(8'd4, 1200, 1300, 1, 1'b0, 16'h0000, 1'b1));
    endtask

    // all-ones and all-zeros field values
    task automatic test_field_extremes();
        send_site(mk_site(8'd255, '1, '1, 16'hFFFF, 1'b1, 16'h0000, 1'b0));
        send_site(mk_site(8'd255, '0, '0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0));
        send_site(mk_site(8'd0, '0, '1, 16'h0001, 1'b1, 16'hFFFF, 1'b1));
    endtask

    // smallest and largest desert_gap
    task automatic test_gap_limits();
        set_gap('0);
        send_site(mk_site(8'd3, 1000, 1100, 2, 1'b1, 16'h0100, 1'b0));
        // touching site: gap zero stays
        send_site(mk_site(8'd3, 1100, 1200, 2, 1'b1, 16'h0200, 1'b0));
        // gap of one already breaks
        send_site(mk_site(8'd3, 1201, 1300, 2, 1'b1, 16'h0300, 1'b1));
        set_gap('1);
        send_site(mk_site(8'd3, '0, '0, 2, 1'b1, 16'h0400, 1'b0));
        // largest possible gap never exceeds the limit
        send_site(mk_site(8'd3, '1, '1, 2, 1'b1, 16'h0500, 1'b1));
        set_gap(DESERT_GAP_RST);
    endtask

    // one long back-to-back foreground run, count and score keep accumulating
    task automatic test_long_run();
        no_idle = 1'b1;
        for (int i = 0; i < LONG_RUN_SITES; i++)
            send_site(mk_site(8'd5, 0, 10, 1, 1'b1, 16'hFFFF, i == LONG_RUN_SITES - 1));
        no_idle = 1'b0;
    endtask

    // mostly sorted streams with random content, some noise and broken order
    function automatic site_t random_site();
        site_t            st;
        logic [POS_W-1:0] step;
        if ($urandom_range(0, 99) < 12) begin
            st.chrom = CHROM_W'($urandom);
            st.start = POS_W'($urandom);
            st.stop  = POS_W'($urandom);
            st.reads = READS_W'($urandom);
            st.cls   = 1'($urandom);
            st.score = SSCORE_W'($urandom);
            st.last  = ($urandom_range(0, 19) == 0);
            gen_chrom = st.chrom;
            gen_pos   = st.stop;
            return st;
        end
        if ($urandom_range(0, 19) == 0) gen_chrom = gen_chrom + 8'd1;
        case ($urandom_range(0, 6))
            0, 1, 2: step = POS_W'($urandom_range(0, 40));
            3:       step = POS_W'(gap_limit);
            4:       step = POS_W'(gap_limit + 1'b1);
            5:       step = POS_W'(-$urandom_range(1, 50));
            default: step = POS_W'($urandom);
        endcase
        if ($urandom_range(0, 9) < 3) gen_cls = ~gen_cls;
        st.chrom = gen_chrom;
        st.start = gen_pos + step;
        st.stop  = st.start + POS_W'($urandom_range(1, 200));
        st.reads = ($urandom_range(0, 99) < 8) ? '0 : READS_W'($urandom_range(1, 65535));
        st.cls   = gen_cls;
        st.score = SSCORE_W'($urandom_range(0, 65535));
        st.last  = ($urandom_range(0, 99) < 3);
        gen_pos  = st.stop;
        return st;
    endfunction

    task automatic test_random_traffic(input logic [DGAP_W-1:0] gap_setting, input int count);
        set_gap(gap_setting);
        for (int i = 0; i < count; i++) begin
            // switch between idle-free stretches and random idling
            if (i % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_site(random_site());
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        // single synchronous reset at the start
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_runs_and_breaks();
        test_flush_cases();
        test_field_extremes();
        test_gap_limits();
        test_long_run();
        test_random_traffic('0, 90);
        test_random_traffic(DGAP_W'($urandom_range(1, 300)), 90);
        test_random_traffic('1, 90);
        test_random_traffic(DGAP_W'($urandom), 90);
        test_random_traffic(DESERT_GAP_RST, 90);

        // drain and give any stray domain time to show up
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (domains_due.size() != 0) begin
            errors++;
            $display("%0d predicted domains never arrived", domains_due.size());
        end
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
